FILE: src/sfr_pkg.sv
// shared types and constants for the sensor frame receiver
package sfr_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned POS_W         = 4;
    localparam int unsigned WORD_W        = 16;
    localparam int unsigned CAPTURE_FIRST = 3;
    localparam int unsigned CAPTURE_LAST  = 8;
    localparam int unsigned NUM_CAPTURE   = CAPTURE_LAST - CAPTURE_FIRST + 1;
    localparam int unsigned RESULT_W      = 3 * WORD_W + 1;
    localparam int unsigned M_TDATA_W     = ((RESULT_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h16;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [POS_W-1:0]  pos_t;

    typedef struct packed {
        logic shift_en;
        logic frame_done;
        logic sum_ok;
    } ctrl_t;

endpackage

FILE: src/sensor_frame_receiver_core.sv
// Sensor frame receiver: takes one received byte per transfer and accepts a byte in every
// cycle. While idle it drops all bytes but the header byte (cfg register, reset 0x16), which
// opens a frame of FRAME_BYTES bytes. Frame bytes 3 to 8 shift through a chain of six byte
// cells; on the last byte one result is loaded into the output register, holding the
// three big-endian 16-bit raw values and a flag that the 8-bit wrapping sum of all
// earlier bytes equals the last byte. Input is held off only while the output register
// holds a result that is not taken.
module sensor_frame_receiver_core #(
    parameter int unsigned FRAME_BYTES = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [sfr_pkg::BYTE_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sfr_pkg::BYTE_W-1:0]    s_tdata,  // rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // concentration_raw, flow_raw, temperature_raw, checksum_ok, zero fill
    output logic [sfr_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned NC = sfr_pkg::NUM_CAPTURE;

    sfr_pkg::byte_t header_reg;
    sfr_pkg::ctrl_t ctrl;
    sfr_pkg::byte_t chain [NC+1];
    logic           accept;

    logic                          m_tvalid_reg;
    logic [sfr_pkg::M_TDATA_W-1:0] m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= sfr_pkg::HEADER_RESET;
        end else if (cfg_wen) begin
            header_reg <= cfg_wdata;
        end
    end

    sfr_ctrl #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .rx_byte    (s_tdata),
        .header_byte(header_reg),
        .ctrl       (ctrl)
    );

    assign chain[0] = s_tdata;

    for (genvar i = 0; i < NC; i++) begin : g_cell
        sfr_cell u_cell (
            .aclk    (aclk),
            .shift_en(ctrl.shift_en),
            .byte_in (chain[i]),
            .byte_out(chain[i+1])
        );
    end

    // oldest byte sits in the last cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.frame_done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.frame_done) begin
            m_tdata_reg <= {
                {(sfr_pkg::M_TDATA_W - sfr_pkg::RESULT_W){1'b0}},
                ctrl.sum_ok,
                chain[2], chain[1],
                chain[4], chain[3],
                chain[6], chain[5]
            };
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: src/sfr_cell.sv
// one byte cell of the capture chain
module sfr_cell (
    input  logic          aclk,
    input  logic          shift_en,
    input  sfr_pkg::byte_t byte_in,
    output sfr_pkg::byte_t byte_out
);

    sfr_pkg::byte_t data_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= byte_in;
        end
    end

    assign byte_out = data_reg;

endmodule

FILE: src/sfr_ctrl.sv
// frame sync, byte position and running checksum
module sfr_ctrl #(
    parameter int unsigned FRAME_BYTES = 12
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  sfr_pkg::byte_t rx_byte,
    input  sfr_pkg::byte_t header_byte,
    output sfr_pkg::ctrl_t ctrl
);

    localparam sfr_pkg::pos_t LAST_POS  = sfr_pkg::POS_W'(FRAME_BYTES - 1);
    localparam sfr_pkg::pos_t FIRST_CAP = sfr_pkg::POS_W'(sfr_pkg::CAPTURE_FIRST);
    localparam sfr_pkg::pos_t LAST_CAP  = sfr_pkg::POS_W'(sfr_pkg::CAPTURE_LAST);

    logic           in_frame_reg, in_frame_next;
    sfr_pkg::pos_t  pos_reg, pos_next;
    sfr_pkg::byte_t sum_reg, sum_next;

    always_comb begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        ctrl          = '0;
        if (accept) begin
            if (!in_frame_reg) begin
                if (rx_byte == header_byte) begin
                    in_frame_next = 1'b1;
                    pos_next      = sfr_pkg::POS_W'(1);
                    sum_next      = rx_byte;
                end
            end else if (pos_reg == LAST_POS) begin
                ctrl.frame_done = 1'b1;
                ctrl.sum_ok     = (sum_reg == rx_byte);
                in_frame_next   = 1'b0;
                pos_next        = '0;
                sum_next        = '0;
            end else begin
                ctrl.shift_en = (pos_reg >= FIRST_CAP) && (pos_reg <= LAST_CAP);
                sum_next      = sum_reg + rx_byte;
                pos_next      = pos_reg + sfr_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            sum_reg      <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
        end
    end

endmodule
